FILE: hw/rtl/bcdc_pkg.sv
// shared types, codes and bcd helper for the bcd time-of-day clock
// no dependencies
`default_nettype none

package bcdc_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned EntryW  = 16;
  localparam int unsigned BcdW    = 8;
  localparam int unsigned PaddrW  = 3;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(1000);
  localparam logic [BcdW-1:0]    WrapSixty   = 8'h60;
  localparam logic [BcdW-1:0]    WrapDay     = 8'h24;
  localparam logic [DigitW-1:0]  DigitMax    = 4'd9;
  localparam logic [0:0]         RegPeriod   = 1'b0;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_ZERO_SEC  = 3'd1,
    FUNC_INC_MIN   = 3'd2,
    FUNC_INC_HOUR  = 3'd3,
    FUNC_ENTER_SET = 3'd4,
    FUNC_DIGIT     = 3'd5,
    FUNC_COMMIT    = 3'd6,
    FUNC_CANCEL    = 3'd7
  } func_e;

  typedef struct packed {
    logic [5:0]        hours_bcd;
    logic [6:0]        minutes_bcd;
    logic [6:0]        seconds_bcd;
    logic              in_set_mode;
    logic [EntryW-1:0] entry_value;
    logic              store_strobe;
    logic              time_changed;
  } result_t;

  // bcd increment with decimal adjust and wrap to zero
  function automatic logic [BcdW-1:0] bcd_inc(input logic [BcdW-1:0] v,
                                               input logic [BcdW-1:0] wrap_at);
    logic [BcdW-1:0] s;
    s = v + 8'd1;
    if (s[3:0] >= 4'hA) begin
      s = s + 8'h06;
    end
    if (s >= wrap_at) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bcdc_if.sv
// item channels of the bcd clock: input commands and result items
// depends on bcdc_pkg
`default_nettype none

interface bcdc_in_if;
  import bcdc_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [DigitW-1:0]   digit;
  modport source (output valid, func, digit, input ready);
  modport sink   (input valid, func, digit, output ready);
endinterface

interface bcdc_out_if;
  import bcdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [5:0]        hours_bcd;
  logic [6:0]        minutes_bcd;
  logic [6:0]        seconds_bcd;
  logic              in_set_mode;
  logic [EntryW-1:0] entry_value;
  logic              store_strobe;
  logic              time_changed;
  modport source (output valid, hours_bcd, minutes_bcd, seconds_bcd, in_set_mode,
                  entry_value, store_strobe, time_changed, input ready);
  modport sink   (input valid, hours_bcd, minutes_bcd, seconds_bcd, in_set_mode,
                  entry_value, store_strobe, time_changed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bcdc_apb_regs.sv
// apb register file holding the ticks-per-second period
// depends on bcdc_pkg
`default_nettype none

module bcdc_apb_regs
  import bcdc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PaddrW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [PeriodW-1:0] period_o
);

  logic [PeriodW-1:0] period_q, period_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegPeriod);

  always_comb begin
    period_d = period_q;
    if (wr_en) begin
      period_d = pwdata[PeriodW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else begin
      period_q <= period_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegPeriod) begin
      prdata = {{(32-PeriodW){1'b0}}, period_q};
    end
  end

  assign period_o = period_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bcdc_time_core.sv
// time-of-day state and its single-pass update for one item
// depends on bcdc_pkg
`default_nettype none

module bcdc_time_core
  import bcdc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [DigitW-1:0]  digit_i,
  input  wire logic [PeriodW-1:0] period_i,
  output result_t                 result_o
);

  logic [BcdW-1:0]    sec_q, sec_d, min_q, min_d, hour_q, hour_d;
  logic [PeriodW-1:0] sub_q, sub_d;
  logic               set_q, set_d;
  logic [EntryW-1:0]  entry_q, entry_d;
  logic               strobe, changed;
  logic [PeriodW:0]   sub_inc;
  logic [BcdW-1:0]    sec_inc, min_inc;

  assign sub_inc = {1'b0, sub_q} + {{PeriodW{1'b0}}, 1'b1};
  assign sec_inc = bcd_inc(sec_q, WrapSixty);
  assign min_inc = bcd_inc(min_q, WrapSixty);

  always_comb begin
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    sub_d   = sub_q;
    set_d   = set_q;
    entry_d = entry_q;
    strobe  = 1'b0;
    changed = 1'b0;
    unique case (func_e'(func_i))
      FUNC_TICK: begin
        // a lowered period wraps on the next tick
        if (sub_inc >= {1'b0, period_i}) begin
          sub_d   = '0;
          changed = 1'b1;
          sec_d   = sec_inc;
          if (sec_inc == '0) begin
            min_d = min_inc;
            if (min_inc == '0) begin
              hour_d = bcd_inc(hour_q, WrapDay);
            end
          end
        end else begin
          sub_d = sub_inc[PeriodW-1:0];
        end
      end
      FUNC_ZERO_SEC: begin
        sec_d   = '0;
        sub_d   = '0;
        changed = 1'b1;
      end
      FUNC_INC_MIN: begin
        min_d   = min_inc;
        changed = 1'b1;
      end
      FUNC_INC_HOUR: begin
        hour_d  = bcd_inc(hour_q, WrapDay);
        changed = 1'b1;
      end
      FUNC_ENTER_SET: begin
        if (!set_q) begin
          set_d   = 1'b1;
          entry_d = '0;
        end
      end
      FUNC_DIGIT: begin
        if (set_q && digit_i <= DigitMax) begin
          entry_d = {entry_q[EntryW-5:0], digit_i};
        end
      end
      FUNC_COMMIT: begin
        if (set_q) begin
          if (entry_q[15:8] < WrapDay && entry_q[7:0] < WrapSixty) begin
            min_d   = entry_q[7:0];
            hour_d  = entry_q[15:8];
            sec_d   = '0;
            sub_d   = '0;
            strobe  = 1'b1;
            changed = 1'b1;
          end
          set_d = 1'b0;
        end
      end
      FUNC_CANCEL: begin
        set_d = 1'b0;
      end
      default: begin
        set_d = set_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      sub_q   <= '0;
      set_q   <= 1'b0;
      entry_q <= '0;
    end else if (step_i) begin
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      sub_q   <= sub_d;
      set_q   <= set_d;
      entry_q <= entry_d;
    end
  end

  always_comb begin
    result_o.hours_bcd    = hour_d[5:0];
    result_o.minutes_bcd  = min_d[6:0];
    result_o.seconds_bcd  = sec_d[6:0];
    result_o.in_set_mode  = set_d;
    result_o.entry_value  = entry_d;
    result_o.store_strobe = strobe;
    result_o.time_changed = changed;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bcd_clock_with_time_entry_core.sv
// top level of the bcd time-of-day clock with keyed time entry
// an accepted item passes the input register, then the result register; the state update
// is one pass of logic in bcdc_time_core; throughput: one item per cycle unless out_m stalls
// reset: asynchronous active low, time, sub-second count, set mode and entry cleared,
// period set to 1000 ticks
// depends on bcdc_pkg, bcdc_if, bcdc_apb_regs, bcdc_time_core
`default_nettype none

module bcd_clock_with_time_entry_core
  import bcdc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bcdc_in_if.sink                in_s,
  bcdc_out_if.source             out_m,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic               stg_vld_q, stg_vld_d;
  logic [FuncW-1:0]   func_q, func_d;
  logic [DigitW-1:0]  digit_q, digit_d;
  logic               out_vld_q, out_vld_d;
  result_t            res_q, res_d;
  result_t            core_res;
  logic               adv, in_acc, step;
  logic [PeriodW-1:0] period;

  bcdc_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .period_o (period)
  );

  // result register frees up when empty or being taken
  assign adv         = !out_vld_q || out_m.ready;
  assign in_s.ready  = !stg_vld_q || adv;
  assign in_acc      = in_s.valid && in_s.ready;
  assign step        = stg_vld_q && adv;

  bcdc_time_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .func_i   (func_q),
    .digit_i  (digit_q),
    .period_i (period),
    .result_o (core_res)
  );

  always_comb begin
    stg_vld_d = stg_vld_q;
    func_d    = func_q;
    digit_d   = digit_q;
    if (in_acc) begin
      stg_vld_d = 1'b1;
      func_d    = in_s.func;
      digit_d   = in_s.digit;
    end else if (adv) begin
      stg_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (adv) begin
      out_vld_d = stg_vld_q;
      if (stg_vld_q) begin
        res_d = core_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    digit_q <= digit_d;
    res_q   <= res_d;
  end

  assign out_m.valid        = out_vld_q;
  assign out_m.hours_bcd    = res_q.hours_bcd;
  assign out_m.minutes_bcd  = res_q.minutes_bcd;
  assign out_m.seconds_bcd  = res_q.seconds_bcd;
  assign out_m.in_set_mode  = res_q.in_set_mode;
  assign out_m.entry_value  = res_q.entry_value;
  assign out_m.store_strobe = res_q.store_strobe;
  assign out_m.time_changed = res_q.time_changed;

endmodule

`default_nettype wire
